// ===== rtl/clt_pkg.sv =====
// Shared types and constants for the character LCD tick controller.
// Transaction structs, request mode codes, init phases and LCD command bytes.
// No dependencies.
`timescale 1ns / 1ps

package clt_pkg;

	// Character queue sizing
	localparam int BUFFER_DEPTH = 16;
	localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

	// LCD command bytes
	localparam logic [7:0] CMD_FUNCTION_SET = 8'h3C;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] CMD_LINE0        = 8'h80;
	localparam logic [7:0] CMD_LINE1        = 8'hC0;
	localparam logic [7:0] ASCII_ZERO       = 8'h30;

	// Init sequence tick marks
	localparam logic [5:0] FUNC_SEND_TICK  = 6'd35;
	localparam logic [5:0] FUNC_END_TICK   = 6'd38;
	localparam logic [5:0] DISP_SEND_TICK  = 6'd2;
	localparam logic [5:0] DISP_END_TICK   = 6'd4;
	localparam logic [5:0] CLEAR_SEND_TICK = 6'd2;

	// Enable pulse drops on this tick count
	localparam logic [1:0] PULSE_LAST_TICK = 2'd2;

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_INIT   = 3'd1,
		MODE_QUEUE  = 3'd2,
		MODE_CURSOR = 3'd3,
		MODE_CLEAR  = 3'd4,
		MODE_NUMBER = 3'd5,
		MODE_RAW    = 3'd6,
		MODE_NOP    = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FUNC  = 2'd1,
		PH_DISP  = 2'd2,
		PH_CLEAR = 2'd3
	} init_phase_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] data_byte;
		logic [3:0] column;
		logic       row;
	} lcd_req_t;

	typedef struct packed {
		logic       reg_select;
		logic [7:0] data_bus;
		logic       enable_line;
		logic       busy_res;
		logic       dropped;
	} lcd_rsp_t;

endpackage

// ===== rtl/clt_engine.sv =====
// Controller state and per-transaction update for the character LCD tick controller.
// Holds init sequencer, enable pulse timer, character queue and LCD line levels.
// Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_engine import clt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  lcd_req_t item,
	output lcd_rsp_t result
);

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	// State registers
	init_phase_t      phase_q, phase_n;
	logic [5:0]       ticks_q, ticks_n;
	logic             pact_q, pact_n;
	logic [1:0]       pticks_q, pticks_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [CNT_W-1:0] didx_q, didx_n;
	logic             dpend_q, dpend_n;
	logic             rs_q, rs_n;
	logic [7:0]       bus_q, bus_n;
	logic             strobe_q, strobe_n;
	logic [7:0]       store_q [BUFFER_DEPTH];

	// Queue write ports (put-number writes two entries at once)
	logic             wr0_en, wr1_en;
	logic [IDX_W-1:0] wr0_idx, wr1_idx;
	logic [7:0]       wr0_dat, wr1_dat;
	logic             lost;

	// Decimal split: n/10 by reciprocal multiply, exact for every 8-bit n (n < 256)
	logic [15:0] recip_prod;
	logic [4:0]  tens;
	logic [7:0]  ones;
	logic [7:0]  tens_ch, ones_ch;

	assign recip_prod = {8'd0, item.data_byte} * 16'd205;
	assign tens       = recip_prod[15:11];
	assign ones       = item.data_byte - ({3'd0, tens} << 3) - ({3'd0, tens} << 1);
	assign tens_ch    = ASCII_ZERO + {3'd0, tens};
	assign ones_ch    = ASCII_ZERO + ones;

	// Next-state logic for one transaction
	always_comb begin
		phase_n  = phase_q;
		ticks_n  = ticks_q;
		pact_n   = pact_q;
		pticks_n = pticks_q;
		cnt_n    = cnt_q;
		didx_n   = didx_q;
		dpend_n  = dpend_q;
		rs_n     = rs_q;
		bus_n    = bus_q;
		strobe_n = strobe_q;
		wr0_en   = 1'b0;
		wr1_en   = 1'b0;
		wr0_idx  = cnt_q[IDX_W-1:0];
		wr1_idx  = cnt_q[IDX_W-1:0];
		wr0_dat  = item.data_byte;
		wr1_dat  = ones_ch;
		lost     = 1'b0;
		if (step) begin
			unique case (item.mode)
				MODE_TICK: begin
					// init sequencer
					if (phase_q != PH_IDLE) begin
						ticks_n = ticks_q + 6'd1;
						case (phase_q)
							PH_FUNC: begin
								if (ticks_n == FUNC_SEND_TICK) begin
									rs_n   = 1'b0;
									bus_n  = CMD_FUNCTION_SET;
									pact_n = 1'b1;
								end
								if (ticks_n == FUNC_END_TICK) begin
									phase_n = PH_DISP;
									ticks_n = 6'd0;
								end
							end
							PH_DISP: begin
								if (ticks_n == DISP_SEND_TICK) begin
									rs_n   = 1'b0;
									bus_n  = CMD_DISPLAY_ON;
									pact_n = 1'b1;
								end
								if (ticks_n == DISP_END_TICK) begin
									phase_n = PH_CLEAR;
									ticks_n = 6'd0;
								end
							end
							default: begin
								if (ticks_n >= CLEAR_SEND_TICK) begin
									rs_n    = 1'b0;
									bus_n   = CMD_CLEAR;
									pact_n  = 1'b1;
									phase_n = PH_IDLE;
								end
							end
						endcase
					end
					// enable pulse, a byte armed on this tick strobes at once
					if (pact_n) begin
						strobe_n = 1'b1;
						if (pticks_q >= PULSE_LAST_TICK) begin
							strobe_n = 1'b0;
							pticks_n = 2'd0;
							pact_n   = 1'b0;
						end else begin
							pticks_n = pticks_q + 2'd1;
						end
					end else if (dpend_q && phase_n == PH_IDLE) begin
						// drain one queued character, or close out the drain
						if (didx_q < cnt_q) begin
							rs_n   = 1'b1;
							bus_n  = store_q[didx_q[IDX_W-1:0]];
							pact_n = 1'b1;
							didx_n = didx_q + CNT_ONE;
						end else begin
							dpend_n = 1'b0;
							didx_n  = '0;
							cnt_n   = '0;
						end
					end
				end
				MODE_INIT: begin
					phase_n = PH_FUNC;
					ticks_n = 6'd0;
				end
				MODE_QUEUE: begin
					if (cnt_q < CNT_FULL) begin
						wr0_en  = 1'b1;
						cnt_n   = cnt_q + CNT_ONE;
						dpend_n = 1'b1;
					end else begin
						lost = 1'b1;
					end
				end
				MODE_CURSOR: begin
					rs_n   = 1'b0;
					bus_n  = (item.row ? CMD_LINE1 : CMD_LINE0) + {4'd0, item.column};
					pact_n = 1'b1;
				end
				MODE_CLEAR: begin
					rs_n   = 1'b0;
					bus_n  = CMD_CLEAR;
					pact_n = 1'b1;
				end
				MODE_NUMBER: begin
					// tens digit first, then ones; each one dropped on its own
					wr0_dat = tens_ch;
					if (cnt_q < CNT_FULL) begin
						wr0_en  = 1'b1;
						cnt_n   = cnt_q + CNT_ONE;
						dpend_n = 1'b1;
					end else begin
						lost = 1'b1;
					end
					wr1_idx = cnt_n[IDX_W-1:0];
					if (cnt_n < CNT_FULL) begin
						wr1_en  = 1'b1;
						cnt_n   = cnt_n + CNT_ONE;
						dpend_n = 1'b1;
					end else begin
						lost = 1'b1;
					end
				end
				MODE_RAW: begin
					rs_n   = 1'b0;
					bus_n  = item.data_byte;
					pact_n = 1'b1;
				end
				MODE_NOP: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Result seen after the update
	always_comb begin
		result.reg_select  = rs_n;
		result.data_bus    = bus_n;
		result.enable_line = strobe_n;
		result.busy_res    = (phase_n != PH_IDLE) || pact_n || dpend_n;
		result.dropped     = lost;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			ticks_q  <= 6'd0;
			pact_q   <= 1'b0;
			pticks_q <= 2'd0;
			cnt_q    <= '0;
			didx_q   <= '0;
			dpend_q  <= 1'b0;
			rs_q     <= 1'b0;
			bus_q    <= 8'd0;
			strobe_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			ticks_q  <= ticks_n;
			pact_q   <= pact_n;
			pticks_q <= pticks_n;
			cnt_q    <= cnt_n;
			didx_q   <= didx_n;
			dpend_q  <= dpend_n;
			rs_q     <= rs_n;
			bus_q    <= bus_n;
			strobe_q <= strobe_n;
		end
	end

	// Character queue storage, entries are only read below the fill count
	always_ff @(posedge clk) begin
		if (wr0_en) begin
			store_q[wr0_idx] <= wr0_dat;
		end
		if (wr1_en) begin
			store_q[wr1_idx] <= wr1_dat;
		end
	end

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("queue fill count beyond depth");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		didx_q <= cnt_q)
		else $error("drain index past fill count");

	a_pulse_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!pact_q |-> (pticks_q == 2'd0))
		else $error("pulse tick count left over with no pulse armed");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		result.dropped |-> (cnt_n == CNT_FULL))
		else $error("character dropped while queue had room");

endmodule

// ===== rtl/char_lcd_tick_controller_unit.sv =====
// Top level of the character LCD tick controller: valid/stall channels around the engine.
// Input register, controller update, result register.
// Depends on clt_pkg and clt_engine.
`timescale 1ns / 1ps

// One request or tick transaction is taken per clock while req_stall is low, and each
// gives exactly one result transaction: the request is captured in an input
// register, the controller state is updated from it as it leaves that register, and
// the LCD line levels, busy and dropped flags land in the result register.
// The sustained rate is one transaction per cycle while rsp_stall is low, as the
// state update is combinational. A waiting result does not block the next request;
// req_stall rises only when both the input and result registers are full and
// rsp_stall is high. The character queue holds BUFFER_DEPTH bytes; queue writes to a
// full queue are discarded and reported through dropped. The R/W line is not driven.
module char_lcd_tick_controller_unit import clt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  lcd_req_t req_data,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output lcd_rsp_t rsp_data
);

	logic     valid_s1;
	lcd_req_t item_s1;
	logic     valid_s2;
	lcd_rsp_t result_s2;
	lcd_rsp_t result;
	logic     advance;
	logic     req_take;

	// Handshake control
	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign req_take  = req_valid && !req_stall;

	// Controller state and update
	clt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (valid_s2 && !rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (req_take) begin
			item_s1 <= req_data;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp_data  = result_s2;

	// Checks
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid)
		else $error("advanced transaction produced no result");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2))
		else $error("request stalled with a free register");

endmodule
